@@ hdl/circular_record_queue_with_search_macros.svh @@
// Assertion macros for the record queue.
// Expects signals named clk and rst in the scope of each use.
`ifndef CIRCULAR_RECORD_QUEUE_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_RECORD_QUEUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication
`define CRQS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/crqs_pkg.sv @@
// Shared types and constants for the record queue.
// No dependencies.
package crqs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CAP_W     = 7;
  localparam int ID_W      = 32;
  localparam int PRICE_W   = 32;
  localparam int BYTE_W    = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_FIND = 2'd2,
    OP_UPD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [BYTE_W-1:0]  doors;
    logic [BYTE_W-1:0]  series;
  } rec_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [BYTE_W-1:0]  doors;
    logic [PRICE_W-1:0] price;
    logic [BYTE_W-1:0]  series;
    logic [CAP_W-1:0]   occupancy;
  } rsp_t;

  // configuration side: flush pulse and effective capacity
  typedef struct packed {
    logic             clear;
    logic [CAP_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [CAP_W-1:0] count;
  } stat_t;

endpackage

@@ hdl/crqs_if.sv @@
// Request and response channel interfaces for the record queue.
// No dependencies.
interface crqs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] car_id;
  logic [7:0]         door_count;
  logic [31:0]        price_cents;
  logic [7:0]         series_code;

  modport source (output valid, operation, car_id, door_count, price_cents, series_code,
                  input ready);
  modport sink (input valid, operation, car_id, door_count, price_cents, series_code,
                output ready);
endinterface

interface crqs_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_id;
  logic [7:0]         out_doors;
  logic [31:0]        out_price;
  logic [7:0]         out_series;
  logic [6:0]         occupancy;

  modport source (output valid, status, out_id, out_doors, out_price, out_series, occupancy,
                  input ready);
  modport sink (input valid, status, out_id, out_doors, out_price, out_series, occupancy,
                output ready);
endinterface

@@ hdl/crqs_seq.sv @@
// Sequencer for the record queue: pointers, record memory and search walk.
// Depends on crqs_pkg and crqs_req_if.
module crqs_seq #(
  parameter int QUEUE_DEPTH = crqs_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  crqs_pkg::cfg_t   cfg,
  crqs_req_if.sink         req,
  input  logic             out_free,
  output logic             push,
  output crqs_pkg::rsp_t   res,
  output crqs_pkg::stat_t  stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int RW = $bits(crqs_pkg::rec_t);

  crqs_pkg::state_t state, state_next;
  crqs_pkg::op_t    op;
  crqs_pkg::op_t    req_op;

  logic [AW-1:0]                 head, tail, chk_slot;
  logic [crqs_pkg::CAP_W-1:0]    count, remaining;
  logic [crqs_pkg::ID_W-1:0]     key_id;
  logic [crqs_pkg::PRICE_W-1:0]  new_price;

  // record memory, one synchronous read port and one write port
  logic [RW-1:0]     mem [QUEUE_DEPTH];
  crqs_pkg::rec_t    rd_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  crqs_pkg::rec_t    wr_data;

  logic accept, hit;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i,
                                        input logic [crqs_pkg::CAP_W-1:0] cap);
    if ((32'(i) + 32'd1) >= 32'(cap)) return '0;
    return i + 1'b1;
  endfunction

  assign req_op = crqs_pkg::op_t'(req.operation);
  assign accept = req.valid && req.ready;
  assign hit    = (rd_q.id == key_id);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= crqs_pkg::rec_t'(mem[rd_addr]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      crqs_pkg::S_IDLE: begin
        if (req.valid) begin
          unique case (req_op)
            crqs_pkg::OP_ENQ: state_next = crqs_pkg::S_PUSH;
            crqs_pkg::OP_DEQ:
              state_next = (count == '0) ? crqs_pkg::S_PUSH : crqs_pkg::S_FETCH;
            default:
              state_next = (count == '0) ? crqs_pkg::S_PUSH : crqs_pkg::S_SCAN;
          endcase
        end
      end
      crqs_pkg::S_FETCH: state_next = crqs_pkg::S_PUSH;
      crqs_pkg::S_SCAN: begin
        if (hit || remaining == 7'd1) state_next = crqs_pkg::S_PUSH;
      end
      crqs_pkg::S_PUSH: begin
        if (out_free) state_next = crqs_pkg::S_IDLE;
      end
      default: state_next = crqs_pkg::S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    req.ready = (state == crqs_pkg::S_IDLE);
    push      = (state == crqs_pkg::S_PUSH);
    // during the walk the next slot is fetched ahead of the compare
    rd_addr   = (state == crqs_pkg::S_SCAN) ? nxt(chk_slot, cfg.cap) : head;
    wr_en     = 1'b0;
    wr_addr   = tail;
    wr_data   = '{id: req.car_id, price: req.price_cents,
                  doors: req.door_count, series: req.series_code};
    if (state == crqs_pkg::S_IDLE) begin
      wr_en = req.valid && req_op == crqs_pkg::OP_ENQ && count < cfg.cap;
    end else if (state == crqs_pkg::S_SCAN) begin
      wr_en   = hit && op == crqs_pkg::OP_UPD;
      wr_addr = chk_slot;
      wr_data = '{id: rd_q.id, price: new_price, doors: rd_q.doors, series: rd_q.series};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crqs_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg.clear) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (accept) begin
        unique case (req_op)
          crqs_pkg::OP_ENQ: begin
            if (count < cfg.cap) begin
              tail  <= nxt(tail, cfg.cap);
              count <= count + 1'b1;
            end
          end
          crqs_pkg::OP_DEQ: begin
            if (count != '0) begin
              head  <= nxt(head, cfg.cap);
              count <= count - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= req_op;
      key_id    <= req.car_id;
      new_price <= req.price_cents;
      chk_slot  <= head;
      remaining <= count;
      res.status    <= crqs_pkg::ST_OK;
      res.id        <= '1;
      res.doors     <= '0;
      res.price     <= '0;
      res.series    <= '0;
      res.occupancy <= count;
      unique case (req_op)
        crqs_pkg::OP_ENQ: begin
          if (count >= cfg.cap) res.status <= crqs_pkg::ST_FULL;
          else res.occupancy <= count + 1'b1;
        end
        crqs_pkg::OP_DEQ: begin
          if (count == '0) res.status <= crqs_pkg::ST_EMPTY;
          else res.occupancy <= count - 1'b1;
        end
        default: begin
          if (count == '0) res.status <= crqs_pkg::ST_NOTFOUND;
        end
      endcase
    end else if (state == crqs_pkg::S_FETCH) begin
      res.id     <= rd_q.id;
      res.doors  <= rd_q.doors;
      res.price  <= rd_q.price;
      res.series <= rd_q.series;
    end else if (state == crqs_pkg::S_SCAN) begin
      if (hit) begin
        res.id     <= rd_q.id;
        res.doors  <= rd_q.doors;
        res.price  <= (op == crqs_pkg::OP_UPD) ? new_price : rd_q.price;
        res.series <= rd_q.series;
      end else if (remaining == 7'd1) begin
        res.status <= crqs_pkg::ST_NOTFOUND;
      end else begin
        chk_slot  <= nxt(chk_slot, cfg.cap);
        remaining <= remaining - 1'b1;
      end
    end
  end

  assign stat.busy  = (state != crqs_pkg::S_IDLE);
  assign stat.count = count;

endmodule

@@ hdl/crqs_out.sv @@
// Output register for the record queue response channel.
// Depends on crqs_pkg and crqs_rsp_if.
module crqs_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crqs_pkg::rsp_t  res,
  output logic            out_free,
  crqs_rsp_if.source      rsp
);

  logic           valid;
  crqs_pkg::rsp_t held;

  assign out_free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push && out_free) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && out_free) held <= res;
  end

  assign rsp.valid      = valid;
  assign rsp.status     = held.status;
  assign rsp.out_id     = held.id;
  assign rsp.out_doors  = held.doors;
  assign rsp.out_price  = held.price;
  assign rsp.out_series = held.series;
  assign rsp.occupancy  = held.occupancy;

endmodule

@@ hdl/circular_record_queue_with_search.sv @@
// Circular record queue with id search: a FIFO of car records in one memory.
// Beats arrive on req (valid/ready); one response beat leaves on rsp for each.
// Operations: enqueue at the tail, dequeue from the head, find the first record
// from the head by id, update the price of that first match.
// Every response carries a status and the occupancy after the operation.
// Steps from request beat to response: enqueue goes straight to the push state,
// dequeue reads the head record in the fetch state, find/update walks from the
// head in the scan state comparing 1..capacity records until the first match
// or the last record; an empty queue skips to push. The walk compares one record
// a cycle, set by the single memory read port fetching the next slot ahead.
// req.ready is high only while the sequencer is idle, so one operation is in
// flight at a time; the next beat can be taken the cycle after the push.
// A response waiting in the output register does not stop the next request
// being taken, only its own result being pushed.
// If the receiver stalls, the response holds and the sequencer waits.
// Reset (rst, synchronous) empties the queue and sets capacity to 64 slots, clamped to QUEUE_DEPTH.
// Writing cfg_wdata with cfg_we sets the capacity in use and empties the queue;
// 0 acts as 1, anything above QUEUE_DEPTH acts as QUEUE_DEPTH.
// Record memory contents are not cleared; only written slots ever reach a response.
`include "circular_record_queue_with_search_macros.svh"

module circular_record_queue_with_search #(
  parameter int QUEUE_DEPTH = crqs_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  crqs_req_if.sink                    req,
  crqs_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [crqs_pkg::CAP_W-1:0]  cfg_wdata
);

  logic [crqs_pkg::CAP_W-1:0] cap_reg;
  logic [crqs_pkg::CAP_W-1:0] eff_cap;
  crqs_pkg::cfg_t             cfg;
  crqs_pkg::stat_t            stat;
  crqs_pkg::rsp_t             res;
  logic                       push;
  logic                       out_free;
  logic                       req_beat;
  logic                       rsp_full;
  logic                       rsp_fail;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= crqs_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  // clamp into 1..QUEUE_DEPTH; this is the wrap point of head and tail
  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = 7'd1;
    end else if (32'(cap_reg) > QUEUE_DEPTH) begin
      eff_cap = crqs_pkg::CAP_W'(QUEUE_DEPTH);
    end else begin
      eff_cap = cap_reg;
    end
  end

  // the flush rides on the write beat itself
  assign cfg.clear = cfg_we;
  assign cfg.cap   = eff_cap;

  crqs_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .out_free (out_free),
    .push     (push),
    .res      (res),
    .stat     (stat)
  );

  crqs_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .out_free (out_free),
    .rsp      (rsp)
  );

  // checks
  assign req_beat = req.valid && req.ready;
  assign rsp_full = rsp.valid && rsp.status == crqs_pkg::ST_FULL;
  assign rsp_fail = rsp.valid && rsp.status != crqs_pkg::ST_OK;

  `CRQS_ASSERT_NOW(a_count_in_cap, 1'b1, stat.count <= eff_cap, "record count above capacity")
  `CRQS_ASSERT_NEXT(a_accept_busy, req_beat, stat.busy, "request beat left sequencer idle")
  `CRQS_ASSERT_NOW(a_full_occ, rsp_full, rsp.occupancy == eff_cap, "full reported below capacity")
  `CRQS_ASSERT_NOW(a_fail_noid, rsp_fail, rsp.out_id == -32'sd1, "failed operation returned a record")

endmodule
